// ===== design/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer_top; depends on nothing.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int TAB_STEP   = 4;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);

    localparam logic [7:0]  BLANK_CHAR  = 8'h20;
    localparam logic [7:0]  RESET_ATTR  = 8'h07;
    localparam logic [15:0] RESET_BLANK = {RESET_ATTR, BLANK_CHAR};

    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_NL  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_PRINT,
        KIND_NL,
        KIND_CR,
        KIND_TAB,
        KIND_BS
    } kind_t;

    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_CHAR,
        MEM_BS_READ,
        MEM_BS_WRITE,
        MEM_CELL_READ,
        MEM_COPY,
        MEM_FILL
    } mem_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_BS_WR,
        ST_COPY,
        ST_FILL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic    latch;
        mem_op_t mem_op;
        logic    fill_init;
        logic    cur_step;
        logic    cur_home;
        logic    copy_start;
        logic    fill_start;
        logic    set_scroll;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        kind_t kind;
        logic  cur_zero;
        logic  wrap;
        logic  copy_done;
        logic  fill_last;
        logic  out_free;
    } dp_status_t;

endpackage

// ===== design/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through ctrl_cmd_t.
module tcw_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tcw_pkg::dp_status_t    status,
    output tcw_pkg::ctrl_cmd_t     cmd
);
    import tcw_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mem_op = MEM_IDLE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                // reset clearing pass, blanks carry the reset attribute
                cmd.mem_op    = MEM_FILL;
                cmd.fill_init = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESULT;
                case (status.func)
                    FUNC_PUT: begin
                        if (status.kind == KIND_BS) begin
                            if (!status.cur_zero) begin
                                cmd.mem_op   = MEM_BS_READ;
                                cmd.cur_step = 1'b1;
                                state_next   = ST_BS_WR;
                            end
                        end else begin
                            if (status.kind == KIND_PRINT) begin
                                cmd.mem_op = MEM_CHAR;
                            end
                            cmd.cur_step = 1'b1;
                            if (status.wrap) begin
                                cmd.copy_start = 1'b1;
                                cmd.set_scroll = 1'b1;
                                state_next     = ST_COPY;
                            end
                        end
                    end
                    FUNC_READ: begin
                        cmd.mem_op = MEM_CELL_READ;
                    end
                    FUNC_CLEAR: begin
                        cmd.cur_home   = 1'b1;
                        cmd.fill_start = 1'b1;
                        state_next     = ST_FILL;
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_BS_WR: begin
                cmd.mem_op = MEM_BS_WRITE;
                state_next = ST_RESULT;
            end
            ST_COPY: begin
                cmd.mem_op = MEM_COPY;
                if (status.copy_done) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.mem_op = MEM_FILL;
                if (status.fill_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tcw_datapath.sv =====
// Datapath of the text console writer: screen memory, cursor, sweep counters,
// attribute register and output register. Depends on tcw_pkg; driven by tcw_ctrl.
module tcw_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           s_func,
    input  logic [7:0]           s_char_code,
    input  logic [10:0]          s_cell_index,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [10:0]          m_cursor_cell,
    output logic [7:0]           m_cell_char,
    output logic [7:0]           m_cell_attr,
    output logic                 m_scrolled,
    input  tcw_pkg::ctrl_cmd_t   cmd,
    output tcw_pkg::dp_status_t  status
);
    import tcw_pkg::*;

    logic [15:0] screen_mem [CELL_COUNT];
    logic [15:0] rdata_reg;

    func_t       func_reg;
    logic [7:0]  code_reg;
    logic [10:0] idx_reg;
    logic [7:0]  attr_reg;
    logic        scroll_reg;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] wptr_reg, wptr_next;
    logic             pend_reg, pend_next;

    logic             m_valid_reg;
    logic [10:0]      out_cursor_reg;
    logic [7:0]       out_char_reg;
    logic [7:0]       out_attr_reg;
    logic             out_scroll_reg;

    kind_t            kind;
    logic [ROW_W-1:0] step_row;
    logic [COL_W-1:0] step_col;
    logic [COL_W:0]   col_p1, col_p4;
    logic             wrap;
    logic [ADDR_W-1:0] cur_idx;
    logic [31:0]      cur_wide;
    logic [31:0]      idx_wide;
    logic             idx_ok;
    logic             rd_done;
    logic             out_free;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    // cursor cell from row and column
    assign cur_idx  = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg));
    assign cur_wide = 32'(cur_idx);
    assign idx_wide = 32'(idx_reg);
    assign idx_ok   = idx_wide < CELL_COUNT;
    assign rd_done  = rptr_reg == CNT_W'(CELL_COUNT);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (code_reg)
            CODE_NL:  kind = KIND_NL;
            CODE_CR:  kind = KIND_CR;
            CODE_TAB: kind = KIND_TAB;
            CODE_BS:  kind = KIND_BS;
            default:  kind = KIND_PRINT;
        endcase
    end

    // cursor step for the latched code
    assign col_p1 = {1'b0, col_reg} + (COL_W+1)'(1);
    assign col_p4 = {1'b0, col_reg} + (COL_W+1)'(TAB_STEP);

    always_comb begin
        step_row = row_reg;
        step_col = col_reg;
        case (kind)
            KIND_PRINT: begin
                if (col_p1 == (COL_W+1)'(COLUMNS)) begin
                    step_col = '0;
                    step_row = row_reg + ROW_W'(1);
                end else begin
                    step_col = col_p1[COL_W-1:0];
                end
            end
            KIND_TAB: begin
                if (col_p4 >= (COL_W+1)'(COLUMNS)) begin
                    step_col = COL_W'(col_p4 - (COL_W+1)'(COLUMNS));
                    step_row = row_reg + ROW_W'(1);
                end else begin
                    step_col = col_p4[COL_W-1:0];
                end
            end
            KIND_NL: begin
                step_col = '0;
                step_row = row_reg + ROW_W'(1);
            end
            KIND_CR: begin
                step_col = '0;
            end
            KIND_BS: begin
                if (col_reg == '0) begin
                    step_col = COL_W'(COLUMNS - 1);
                    step_row = row_reg - ROW_W'(1);
                end else begin
                    step_col = col_reg - COL_W'(1);
                end
            end
            default: begin
                step_col = col_reg;
            end
        endcase
    end

    assign wrap = step_row == ROW_W'(ROWS);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.cur_home) begin
            row_next = '0;
            col_next = '0;
        end else if (cmd.cur_step) begin
            // a wrap lands in the bottom row after the scroll
            row_next = wrap ? ROW_W'(ROWS - 1) : step_row;
            col_next = step_col;
        end
    end

    // memory port selection and sweep counters
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = cur_idx;
        mem_raddr = cur_idx;
        mem_wdata = {attr_reg, code_reg};
        case (cmd.mem_op)
            MEM_CHAR: begin
                mem_we = 1'b1;
            end
            MEM_BS_READ: begin
                mem_re    = 1'b1;
                mem_raddr = cur_idx - ADDR_W'(1);
            end
            MEM_BS_WRITE: begin
                mem_we    = 1'b1;
                mem_wdata = {rdata_reg[15:8], BLANK_CHAR};
            end
            MEM_CELL_READ: begin
                mem_re    = idx_ok;
                mem_raddr = idx_wide[ADDR_W-1:0];
            end
            MEM_COPY: begin
                mem_re    = !rd_done;
                mem_raddr = rptr_reg[ADDR_W-1:0];
                mem_we    = pend_reg;
                mem_waddr = wptr_reg[ADDR_W-1:0];
                mem_wdata = rdata_reg;
            end
            MEM_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = wptr_reg[ADDR_W-1:0];
                mem_wdata = cmd.fill_init ? RESET_BLANK : {attr_reg, BLANK_CHAR};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        pend_next = (cmd.mem_op == MEM_COPY) && !rd_done;
        if (cmd.copy_start) begin
            rptr_next = CNT_W'(COLUMNS);
            wptr_next = '0;
        end else if (cmd.fill_start) begin
            wptr_next = '0;
        end else begin
            if ((cmd.mem_op == MEM_COPY) && !rd_done) begin
                rptr_next = rptr_reg + CNT_W'(1);
            end
            if (((cmd.mem_op == MEM_COPY) && pend_reg) || (cmd.mem_op == MEM_FILL)) begin
                wptr_next = wptr_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= RESET_ATTR;
            row_reg     <= '0;
            col_reg     <= '0;
            rptr_reg    <= '0;
            wptr_reg    <= '0;
            pend_reg    <= 1'b0;
            scroll_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
            row_reg  <= row_next;
            col_reg  <= col_next;
            rptr_reg <= rptr_next;
            wptr_reg <= wptr_next;
            pend_reg <= pend_next;
            if (cmd.latch) begin
                scroll_reg <= 1'b0;
            end else if (cmd.set_scroll) begin
                scroll_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg <= func_t'(s_func);
            code_reg <= s_char_code;
            idx_reg  <= s_cell_index;
        end
        if (cmd.out_load) begin
            out_cursor_reg <= cur_wide[10:0];
            out_scroll_reg <= scroll_reg;
            if ((func_reg == FUNC_READ) && idx_ok) begin
                out_char_reg <= rdata_reg[7:0];
                out_attr_reg <= rdata_reg[15:8];
            end else begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    assign status.func      = func_reg;
    assign status.kind      = kind;
    assign status.cur_zero  = (row_reg == '0) && (col_reg == '0);
    assign status.wrap      = wrap;
    assign status.copy_done = rd_done && !pend_reg;
    assign status.fill_last = wptr_reg == CNT_W'(CELL_COUNT - 1);
    assign status.out_free  = out_free;

    assign m_valid       = m_valid_reg;
    assign m_cursor_cell = out_cursor_reg;
    assign m_cell_char   = out_char_reg;
    assign m_cell_attr   = out_attr_reg;
    assign m_scrolled    = out_scroll_reg;

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over a pending transfer");

    a_copy_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (32'(rptr_reg) == 32'(wptr_reg) + COLUMNS + 1))
        else $error("scroll read and write pointers out of step");

    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (32'(mem_waddr) < CELL_COUNT))
        else $error("screen write outside the cell range");

endmodule

// ===== design/text_console_writer_top.sv =====
// Top level of the 80x25 text console writer.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.

// Each accepted item produces exactly one result. After reset the block runs a
// clearing pass over the screen memory (one cell per cycle) with s_ready low;
// cfg_wr_en writes are taken throughout. A put of a printable code, tab, newline
// or carriage return that does not scroll, a cell read and the unused func code
// pass through accept, execute and load of the output register; backspace away
// from cell zero adds a write-back step before the load. A put that runs past the
// last cell scrolls the screen through the single read port and single write
// port of the screen memory: it moves 24 rows up one cell per cycle (1920 reads,
// the trailing write and a handover step), then blanks the bottom row. Clear
// screen sweeps all 2000 cells. A new item is taken while the previous result
// still waits in the output register; its result waits until that transfer is
// done.
module text_console_writer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_char_code,
    input  logic [10:0] s_cell_index,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_cursor_cell,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic        m_scrolled
);
    import tcw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_func        (s_func),
        .s_char_code   (s_char_code),
        .s_cell_index  (s_cell_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_cell (m_cursor_cell),
        .m_cell_char   (m_cell_char),
        .m_cell_attr   (m_cell_attr),
        .m_scrolled    (m_scrolled),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_top: drives put, read, clear and
// unused operations, predicts screen and cursor state, checks every result.
// Depends on tcw_pkg and the design files under design/.
module tb_top;
    import tcw_pkg::*;

    localparam int STALL_LIMIT = 25000;

    typedef struct packed {
        logic [10:0] cursor_cell;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
    } console_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [7:0]  s_char_code;
    logic [10:0] s_cell_index;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        m_valid;
    logic        m_ready;
    logic [10:0] m_cursor_cell;
    logic [7:0]  m_cell_char;
    logic [7:0]  m_cell_attr;
    logic        m_scrolled;

    // Shadow of the block's state
    logic [15:0] screen_shadow [CELL_COUNT];
    int unsigned cursor_shadow;
    logic [7:0]  attr_shadow;

    console_result_t pending_results[$];
    int mismatch_count;
    int items_accepted;
    int stalled_cycles;
    int send_gap_pct;
    int recv_stall_pct;
    int hold_cycles;

    text_console_writer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_char_code   (s_char_code),
        .s_cell_index  (s_cell_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_cell (m_cursor_cell),
        .m_cell_char   (m_cell_char),
        .m_cell_attr   (m_cell_attr),
        .m_scrolled    (m_scrolled)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void blank_screen_shadow();
        for (int k = 0; k < CELL_COUNT; k++) begin
            screen_shadow[k] = {attr_shadow, BLANK_CHAR};
        end
    endfunction

    // Update the shadow state with one operation and return the result it yields.
    function automatic console_result_t apply_console_op(input func_t op,
                                                         input logic [7:0] code,
                                                         input logic [10:0] idx);
        console_result_t res;
        int unsigned cur;
        res = '0;
        cur = cursor_shadow;
        case (op)
            FUNC_PUT: begin
                if (code == CODE_NL) begin
                    cur = (cur / COLUMNS) * COLUMNS + COLUMNS;
                end else if (code == CODE_CR) begin
                    cur = (cur / COLUMNS) * COLUMNS;
                end else if (code == CODE_TAB) begin
                    cur = cur + TAB_STEP;
                end else if (code == CODE_BS) begin
                    if (cur > 0) begin
                        cur = cur - 1;
                        screen_shadow[cur][7:0] = BLANK_CHAR;
                    end
                end else begin
                    screen_shadow[cur] = {attr_shadow, code};
                    cur = cur + 1;
                end
                if (cur >= CELL_COUNT) begin
                    // move every row up one, blank the bottom row
                    for (int k = 0; k + COLUMNS < CELL_COUNT; k++) begin
                        screen_shadow[k] = screen_shadow[k + COLUMNS];
                    end
                    for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++) begin
                        screen_shadow[k] = {attr_shadow, BLANK_CHAR};
                    end
                    cur = cur - COLUMNS;
                    res.scrolled = 1'b1;
                end
                cursor_shadow = cur;
            end
            FUNC_READ: begin
                if (idx < CELL_COUNT) begin
                    {res.cell_attr, res.cell_char} = screen_shadow[idx];
                end
            end
            FUNC_CLEAR: begin
                blank_screen_shadow();
                cursor_shadow = 0;
            end
            default: ;
        endcase
        res.cursor_cell = cursor_shadow[10:0];
        return res;
    endfunction

    function automatic logic [10:0] pick_cell_index();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            return 11'($urandom_range(2047, CELL_COUNT));
        end else if (roll <= 3) begin
            return 11'((cursor_shadow + CELL_COUNT - $urandom_range(90)) % CELL_COUNT);
        end else if (roll <= 5) begin
            return 11'($urandom_range(CELL_COUNT - 1, CELL_COUNT - COLUMNS));
        end
        return 11'($urandom_range(CELL_COUNT - 1));
    endfunction

    task automatic send_console_op(input func_t op, input logic [7:0] code,
                                   input logic [10:0] idx);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= op;
        s_char_code  <= code;
        s_cell_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_console_op(op, code, idx));
        items_accepted++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_text_attribute(input logic [7:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        attr_shadow = value;
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH %s", what);
    endtask

    task automatic test_reset_state();
        send_console_op(FUNC_READ, 8'h00, 11'd0);
        send_console_op(FUNC_READ, 8'hFF, 11'(CELL_COUNT - 1));
        send_console_op(FUNC_READ, 8'h00, 11'(CELL_COUNT));
        send_console_op(FUNC_READ, 8'h00, 11'h7FF);
    endtask

    task automatic test_control_codes();
        send_console_op(FUNC_PUT, CODE_BS, 11'd0);      // backspace at cell zero
        send_console_op(FUNC_PUT, 8'h00, 11'h7FF);
        send_console_op(FUNC_PUT, 8'hFF, 11'd0);
        send_console_op(FUNC_PUT, CODE_BS, 11'd0);
        send_console_op(FUNC_PUT, CODE_TAB, 11'd0);
        send_console_op(FUNC_PUT, CODE_CR, 11'd0);
        send_console_op(FUNC_PUT, CODE_NL, 11'd0);
        send_console_op(FUNC_PUT, 8'h41, 11'd0);
        send_console_op(FUNC_READ, 8'h00, 11'd0);
        send_console_op(FUNC_READ, 8'h00, 11'd1);
        send_console_op(FUNC_READ, 8'h00, 11'(COLUMNS));
        send_console_op(FUNC_NOP, 8'hFF, 11'h7FF);
        send_console_op(FUNC_PUT, CODE_BS, 11'd0);      // back to row start
        send_console_op(FUNC_READ, 8'h00, 11'(COLUMNS));
        send_console_op(FUNC_CLEAR, 8'h00, 11'd0);
        send_console_op(FUNC_READ, 8'h00, 11'(COLUMNS));
        send_console_op(FUNC_READ, 8'h00, 11'd1);
    endtask

    task automatic test_output_backpressure();
        // hold the result side off so the output register and input both fill
        hold_cycles = 300;
        for (int k = 0; k < 12; k++) begin
            send_console_op(FUNC_PUT, 8'(8'h30 + k), 11'($urandom_range(2047)));
        end
        drain_results();
    endtask

    // Mostly lines of text with control codes, plus reads and some noise.
    task automatic test_random_text(input int item_target);
        int start_count;
        int roll;
        int line_len;
        logic [7:0] code;
        start_count = items_accepted;
        while (items_accepted - start_count < item_target) begin
            roll = $urandom_range(99);
            if (roll < 1) begin
                send_console_op(FUNC_CLEAR, 8'($urandom_range(255)),
                                11'($urandom_range(2047)));
            end else if (roll < 5) begin
                send_console_op(FUNC_NOP, 8'($urandom_range(255)),
                                11'($urandom_range(2047)));
            end else if (roll < 20) begin
                repeat ($urandom_range(3, 1)) begin
                    send_console_op(FUNC_READ, 8'($urandom_range(255)), pick_cell_index());
                end
            end else begin
                roll = $urandom_range(99);
                if (roll < 80) line_len = $urandom_range(4);
                else if (roll < 95) line_len = $urandom_range(79, 5);
                else line_len = $urandom_range(120, 80);
                repeat (line_len) begin
                    roll = $urandom_range(99);
                    if (roll < 8) code = CODE_TAB;
                    else if (roll < 16) code = CODE_BS;
                    else code = 8'($urandom_range(255));
                    send_console_op(FUNC_PUT, code, 11'($urandom_range(2047)));
                end
                roll = $urandom_range(99);
                if (roll < 70) begin
                    send_console_op(FUNC_PUT, CODE_NL, 11'($urandom_range(2047)));
                end else if (roll < 90) begin
                    send_console_op(FUNC_PUT, CODE_CR, 11'($urandom_range(2047)));
                end
            end
        end
    endtask

    // Result side: random stalls, or a counted hold-off when one is requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        console_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer: cursor %0d char %02h attr %02h scrolled %0b",
                                          m_cursor_cell, m_cell_char, m_cell_attr, m_scrolled));
            end else begin
                want = pending_results.pop_front();
                if (m_cursor_cell !== want.cursor_cell || m_cell_char !== want.cell_char ||
                    m_cell_attr !== want.cell_attr || m_scrolled !== want.scrolled) begin
                    report_mismatch($sformatf(
                        "cursor exp %0d got %0d, char exp %02h got %02h, attr exp %02h got %02h, scrolled exp %0b got %0b",
                        want.cursor_cell, m_cursor_cell, want.cell_char, m_cell_char,
                        want.cell_attr, m_cell_attr, want.scrolled, m_scrolled));
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_func         = FUNC_PUT;
        s_char_code    = 8'h00;
        s_cell_index   = 11'd0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 8'h00;
        mismatch_count = 0;
        items_accepted = 0;
        stalled_cycles = 0;
        hold_cycles    = 0;
        send_gap_pct   = 11;
        recv_stall_pct = 80;
        attr_shadow    = RESET_ATTR;
        blank_screen_shadow();
        cursor_shadow  = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        write_text_attribute(8'h00);
        test_control_codes();
        write_text_attribute(8'hFF);
        test_random_text(380);

        send_gap_pct   = 80;
        recv_stall_pct = 11;
        write_text_attribute(8'($urandom_range(255)));
        test_random_text(380);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_output_backpressure();
        write_text_attribute(8'($urandom_range(255)));
        test_random_text(360);

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer_top.sv
bench/tb_top.sv
